### hw/rtl/linear_scan_register_allocator_core_defines.svh
// Assertion macros for the register allocator core
`ifndef LINEAR_SCAN_REGISTER_ALLOCATOR_CORE_DEFINES_SVH
`define LINEAR_SCAN_REGISTER_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTH

`define LSRA_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

`define LSRA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define LSRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LSRA_ASSERT(label, expr, msg)
`define LSRA_ASSERT_IMP(label, ante, cons, msg)
`define LSRA_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### hw/rtl/lsra_pkg.sv
// Shared constants and types of the register allocator core
`default_nettype none

package lsra_pkg;

    localparam int PHYS_REGS  = 16;
    localparam int POS_BITS   = 20;
    localparam int VREG_BITS  = 16;
    localparam int END_BITS   = POS_BITS + 1;
    localparam int SLOT_BITS  = $clog2(PHYS_REGS);
    localparam int ORDER_BITS = 32;
    localparam int SPILL_BITS = 16;
    localparam int CFG_BITS   = 5;
    localparam int CFG_IDX_BITS = 2;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_GENERAL_REG_COUNT = 2'd0;
    localparam t_cfg_idx CFG_FLOAT_REG_COUNT   = 2'd1;
    localparam t_cfg_idx CFG_CALLEE_SAVED_BASE = 2'd2;

    localparam logic [CFG_BITS-1:0] RST_GENERAL_REG_COUNT = CFG_BITS'(16);
    localparam logic [CFG_BITS-1:0] RST_FLOAT_REG_COUNT   = CFG_BITS'(16);
    localparam logic [CFG_BITS-1:0] RST_CALLEE_SAVED_BASE = CFG_BITS'(11);

endpackage

`default_nettype wire

### hw/rtl/lsra_ifs.sv
// Channel interfaces: interval input, allocation result and configuration write
`default_nettype none

interface lsra_in_if import lsra_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                first_of_run;
    logic [VREG_BITS-1:0] virt_reg;
    logic [POS_BITS-1:0] start_pos;
    logic [END_BITS-1:0] end_pos;
    logic                is_float;
    logic                crosses_call;

    modport source (output valid, first_of_run, virt_reg, start_pos, end_pos, is_float,
                    crosses_call, input ready);
    modport sink (input valid, first_of_run, virt_reg, start_pos, end_pos, is_float,
                  crosses_call, output ready);
endinterface

interface lsra_out_if import lsra_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [VREG_BITS-1:0]  virt_reg_out;
    logic                  got_register;
    logic [SLOT_BITS-1:0]  phys_reg;
    logic                  evicted;
    logic [VREG_BITS-1:0]  evicted_virt_reg;
    logic [SPILL_BITS-1:0] spill_total;

    modport source (output valid, virt_reg_out, got_register, phys_reg, evicted,
                    evicted_virt_reg, spill_total, input ready);
    modport sink (input valid, virt_reg_out, got_register, phys_reg, evicted,
                  evicted_virt_reg, spill_total, output ready);
endinterface

interface lsra_cfg_if import lsra_pkg::*; ();
    logic                valid;
    logic                ready;
    t_cfg_idx            index;
    logic [CFG_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/linear_scan_register_allocator_core.sv
// Linear-scan register allocator: one live interval in, one allocation result out.
// An interval's result may wait for the output register to empty. The work is done by one
// end-position comparator and one active-table read port, which visit the sixteen slots
// one per cycle: a first sweep expires finished intervals and finds the lowest free
// register, a second sweep (only when none is free) finds the slot with the furthest end.
// Input is taken only between intervals; configuration writes are always taken and apply
// to the next interval.
`default_nettype none

`include "linear_scan_register_allocator_core_defines.svh"

module linear_scan_register_allocator_core import lsra_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    lsra_in_if.sink    i_in,
    lsra_out_if.source o_out,
    lsra_cfg_if.sink   i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_BEST,
        S_DECIDE,
        S_DONE
    } t_state;

    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(PHYS_REGS - 1);
    localparam logic [CFG_BITS-1:0]  DEPTH     = CFG_BITS'(PHYS_REGS);

    t_state r_state;

    logic [CFG_BITS-1:0] r_general_cnt;
    logic [CFG_BITS-1:0] r_float_cnt;
    logic [CFG_BITS-1:0] r_callee_base;

    logic [PHYS_REGS-1:0]  r_valid;
    logic [END_BITS-1:0]   r_slot_end   [PHYS_REGS];
    logic [VREG_BITS-1:0]  r_slot_vreg  [PHYS_REGS];
    logic [ORDER_BITS-1:0] r_slot_order [PHYS_REGS];
    logic [ORDER_BITS-1:0] r_insert_cnt;
    logic [SPILL_BITS-1:0] r_spill_cnt;

    logic [VREG_BITS-1:0] r_vreg;
    logic [POS_BITS-1:0]  r_start;
    logic [END_BITS-1:0]  r_end;
    logic [CFG_BITS-1:0]  r_limit;
    logic [CFG_BITS-1:0]  r_floor;

    logic [SLOT_BITS-1:0]  r_idx;
    logic                  r_found;
    logic [SLOT_BITS-1:0]  r_chosen;
    logic                  r_have;
    logic [SLOT_BITS-1:0]  r_best;
    logic [END_BITS-1:0]   r_best_end;
    logic [ORDER_BITS-1:0] r_best_order;
    logic [VREG_BITS-1:0]  r_best_vreg;

    logic                  r_res_got;
    logic [SLOT_BITS-1:0]  r_res_phys;
    logic                  r_res_ev;
    logic [VREG_BITS-1:0]  r_res_ev_vreg;

    logic                  r_out_valid;
    logic [VREG_BITS-1:0]  r_out_vreg;
    logic                  r_out_got;
    logic [SLOT_BITS-1:0]  r_out_phys;
    logic                  r_out_ev;
    logic [VREG_BITS-1:0]  r_out_ev_vreg;
    logic [SPILL_BITS-1:0] r_out_spill;

    logic [END_BITS-1:0]   cmp_a;
    logic [END_BITS-1:0]   cmp_b;
    logic                  cmp_lt;
    logic [END_BITS-1:0]   rd_end;
    logic [VREG_BITS-1:0]  rd_vreg;
    logic [ORDER_BITS-1:0] rd_order;
    logic                  rd_valid;
    logic [CFG_BITS-1:0]   idx_ext;
    logic                  in_range;
    logic                  live_after;
    logic                  take_best;
    logic                  do_evict;
    logic                  do_fill;
    logic [SLOT_BITS-1:0]  fill_idx;
    logic                  in_acc;
    logic                  out_load;
    logic [CFG_BITS-1:0]   sel_cnt;
    logic [SPILL_BITS-1:0] n_spill_cnt;

    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign out_load    = (r_state == S_DONE) && (!o_out.valid || o_out.ready);

    assign rd_end   = r_slot_end[r_idx];
    assign rd_vreg  = r_slot_vreg[r_idx];
    assign rd_order = r_slot_order[r_idx];
    assign rd_valid = r_valid[r_idx];

    // shared comparator, operands chosen by phase
    always_comb begin
        case (r_state)
            S_SCAN: begin
                cmp_a = {1'b0, r_start};
                cmp_b = rd_end;
            end
            S_BEST: begin
                cmp_a = r_best_end;
                cmp_b = rd_end;
            end
            S_DECIDE: begin
                cmp_a = r_end;
                cmp_b = r_best_end;
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end
    assign cmp_lt = (cmp_a < cmp_b);

    assign idx_ext    = CFG_BITS'(r_idx);
    assign in_range   = (idx_ext >= r_floor) && (idx_ext < r_limit);
    assign live_after = rd_valid && cmp_lt;
    assign take_best  = rd_valid &&
                        (!r_have || cmp_lt ||
                         ((rd_end == r_best_end) && (rd_order < r_best_order)));
    assign do_evict   = !r_found && r_have && cmp_lt;
    assign do_fill    = (r_state == S_DECIDE) && (r_found || do_evict);
    assign fill_idx   = r_found ? r_chosen : r_best;
    assign sel_cnt    = i_in.is_float ? r_float_cnt : r_general_cnt;
    assign n_spill_cnt = (!r_found && (r_spill_cnt != '1)) ? r_spill_cnt + 1'b1
                                                            : r_spill_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_valid       <= '0;
            r_insert_cnt  <= '0;
            r_spill_cnt   <= '0;
            r_general_cnt <= RST_GENERAL_REG_COUNT;
            r_float_cnt   <= RST_FLOAT_REG_COUNT;
            r_callee_base <= RST_CALLEE_SAVED_BASE;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_GENERAL_REG_COUNT: r_general_cnt <= i_cfg.data;
                    CFG_FLOAT_REG_COUNT:   r_float_cnt   <= i_cfg.data;
                    CFG_CALLEE_SAVED_BASE: r_callee_base <= i_cfg.data;
                    default: ;
                endcase
            end
            if (o_out.valid && o_out.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_vreg  <= i_in.virt_reg;
                        r_start <= i_in.start_pos;
                        r_end   <= i_in.end_pos;
                        r_limit <= (sel_cnt > DEPTH) ? DEPTH : sel_cnt;
                        r_floor <= i_in.crosses_call ? r_callee_base : '0;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_have  <= 1'b0;
                        if (i_in.first_of_run) begin
                            r_valid      <= '0;
                            r_insert_cnt <= '0;
                            r_spill_cnt  <= '0;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // expire and look for the lowest free slot in range
                    if (rd_valid && !cmp_lt) begin
                        r_valid[r_idx] <= 1'b0;
                    end
                    if (!r_found && in_range && !live_after) begin
                        r_found  <= 1'b1;
                        r_chosen <= r_idx;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LAST_SLOT) begin
                        r_state <= (r_found || (in_range && !live_after)) ? S_DECIDE
                                                                          : S_BEST;
                    end
                end
                S_BEST: begin
                    if (take_best) begin
                        r_have       <= 1'b1;
                        r_best       <= r_idx;
                        r_best_end   <= rd_end;
                        r_best_order <= rd_order;
                        r_best_vreg  <= rd_vreg;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LAST_SLOT) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (do_fill) begin
                        r_valid[fill_idx] <= 1'b1;
                        r_insert_cnt      <= r_insert_cnt + 1'b1;
                    end
                    r_spill_cnt   <= n_spill_cnt;
                    r_res_got     <= r_found || do_evict;
                    r_res_phys    <= r_found ? r_chosen : (do_evict ? r_best : '0);
                    r_res_ev      <= do_evict;
                    r_res_ev_vreg <= do_evict ? r_best_vreg : '0;
                    r_state       <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_valid   <= 1'b1;
                        r_out_vreg    <= r_vreg;
                        r_out_got     <= r_res_got;
                        r_out_phys    <= r_res_phys;
                        r_out_ev      <= r_res_ev;
                        r_out_ev_vreg <= r_res_ev_vreg;
                        r_out_spill   <= r_spill_cnt;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_fill) begin
            r_slot_end[fill_idx]   <= r_end;
            r_slot_vreg[fill_idx]  <= r_vreg;
            r_slot_order[fill_idx] <= r_insert_cnt;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.virt_reg_out     = r_out_vreg;
    assign o_out.got_register     = r_out_got;
    assign o_out.phys_reg         = r_out_phys;
    assign o_out.evicted          = r_out_ev;
    assign o_out.evicted_virt_reg = r_out_ev_vreg;
    assign o_out.spill_total      = r_out_spill;

    `LSRA_ASSERT_IMP(a_best_only_when_full, r_state == S_BEST, !r_found, "eviction sweep with a free slot found")
    `LSRA_ASSERT_NEXT(a_accept_starts_scan, in_acc, r_state == S_SCAN && r_idx == '0, "transaction did not start the sweep")
    `LSRA_ASSERT_IMP(a_spill_result_clean, o_out.valid && !o_out.got_register, o_out.phys_reg == '0 && !o_out.evicted, "spilled result carries a register or eviction")
    `LSRA_ASSERT_IMP(a_evict_has_reg, o_out.valid && o_out.evicted, o_out.got_register, "eviction without register grant")

endmodule

`default_nettype wire

### tb/sv/lsra_allocation_checker.sv
// Allocation checker: watches the channels, predicts each allocation and compares results
module lsra_allocation_checker import lsra_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    lsra_in_if   in_ch,
    lsra_out_if  out_ch,
    lsra_cfg_if  cfg_ch,
    output int   o_failures,
    output int   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [VREG_BITS-1:0]  vreg;
        logic                  got;
        logic [SLOT_BITS-1:0]  phys;
        logic                  evicted;
        logic [VREG_BITS-1:0]  ev_vreg;
        logic [SPILL_BITS-1:0] spills;
    } t_alloc;

    logic [CFG_BITS-1:0]   gen_count;
    logic [CFG_BITS-1:0]   flt_count;
    logic [CFG_BITS-1:0]   callee_base;
    logic                  slot_busy [PHYS_REGS];
    logic [END_BITS-1:0]   slot_end  [PHYS_REGS];
    logic [VREG_BITS-1:0]  slot_vreg [PHYS_REGS];
    logic [ORDER_BITS-1:0] slot_seq  [PHYS_REGS];
    logic [ORDER_BITS-1:0] seq_next;
    logic [SPILL_BITS-1:0] spill_count;
    t_alloc                expected_allocs [$];

    function automatic void occupy_slot(input int s, input logic [VREG_BITS-1:0] vr,
                                        input logic [END_BITS-1:0] en);
        slot_busy[s] = 1'b1;
        slot_end[s]  = en;
        slot_vreg[s] = vr;
        slot_seq[s]  = seq_next;
        seq_next     = seq_next + 1'b1;
    endfunction

    function automatic t_alloc predict_allocation(input logic first,
                                                  input logic [VREG_BITS-1:0] vr,
                                                  input logic [POS_BITS-1:0] st,
                                                  input logic [END_BITS-1:0] en,
                                                  input logic fl, input logic call);
        int     lim;
        int     flo;
        int     pick;
        int     best;
        bit     found;
        bit     have;
        t_alloc r;
        r      = '0;
        r.vreg = vr;
        found  = 1'b0;
        have   = 1'b0;
        pick   = 0;
        best   = 0;
        if (first) begin
            for (int s = 0; s < PHYS_REGS; s++) slot_busy[s] = 1'b0;
            seq_next    = '0;
            spill_count = '0;
        end
        for (int s = 0; s < PHYS_REGS; s++) begin
            if (slot_busy[s] && slot_end[s] <= {1'b0, st}) slot_busy[s] = 1'b0;
        end
        lim = fl ? int'(flt_count) : int'(gen_count);
        if (lim > PHYS_REGS) lim = PHYS_REGS;
        flo = call ? int'(callee_base) : 0;
        for (int s = flo; s < lim; s++) begin
            if (!found && !slot_busy[s]) begin
                pick  = s;
                found = 1'b1;
            end
        end
        if (found) begin
            occupy_slot(pick, vr, en);
            r.got  = 1'b1;
            r.phys = SLOT_BITS'(pick);
        end else begin
            for (int s = 0; s < PHYS_REGS; s++) begin
                if (slot_busy[s] && (!have || slot_end[s] > slot_end[best] ||
                    (slot_end[s] == slot_end[best] && slot_seq[s] < slot_seq[best]))) begin
                    best = s;
                    have = 1'b1;
                end
            end
            if (have && slot_end[best] > en) begin
                r.evicted = 1'b1;
                r.ev_vreg = slot_vreg[best];
                r.got     = 1'b1;
                r.phys    = SLOT_BITS'(best);
                occupy_slot(best, vr, en);
            end
            if (spill_count != '1) spill_count = spill_count + 1'b1;
        end
        r.spills = spill_count;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_alloc act;
        t_alloc exp_r;
        if (!i_rst_n) begin
            gen_count   = RST_GENERAL_REG_COUNT;
            flt_count   = RST_FLOAT_REG_COUNT;
            callee_base = RST_CALLEE_SAVED_BASE;
            for (int s = 0; s < PHYS_REGS; s++) slot_busy[s] = 1'b0;
            seq_next    = '0;
            spill_count = '0;
            expected_allocs.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_GENERAL_REG_COUNT: gen_count   = cfg_ch.data;
                    CFG_FLOAT_REG_COUNT:   flt_count   = cfg_ch.data;
                    CFG_CALLEE_SAVED_BASE: callee_base = cfg_ch.data;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                act.vreg    = out_ch.virt_reg_out;
                act.got     = out_ch.got_register;
                act.phys    = out_ch.phys_reg;
                act.evicted = out_ch.evicted;
                act.ev_vreg = out_ch.evicted_virt_reg;
                act.spills  = out_ch.spill_total;
                if (expected_allocs.size() == 0) begin
                    o_failures++;
                    if (o_failures <= 10)
                        $display({"%0t: unexpected result vreg=%h got=%b phys=%0d ",
                                  "ev=%b evv=%h spill=%0d"},
                                 $time, act.vreg, act.got, act.phys, act.evicted, act.ev_vreg,
                                 act.spills);
                end else begin
                    exp_r = expected_allocs.pop_front();
                    if (act.vreg !== exp_r.vreg || act.got !== exp_r.got ||
                        act.phys !== exp_r.phys || act.evicted !== exp_r.evicted ||
                        act.ev_vreg !== exp_r.ev_vreg || act.spills !== exp_r.spills) begin
                        o_failures++;
                        if (o_failures <= 10)
                            $display({"%0t: mismatch exp vreg=%h got=%b phys=%0d ev=%b ",
                                      "evv=%h spill=%0d act vreg=%h got=%b phys=%0d ev=%b ",
                                      "evv=%h spill=%0d"},
                                     $time, exp_r.vreg, exp_r.got, exp_r.phys, exp_r.evicted,
                                     exp_r.ev_vreg, exp_r.spills, act.vreg, act.got, act.phys,
                                     act.evicted, act.ev_vreg, act.spills);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_allocs.insert(expected_allocs.size(),
                                       predict_allocation(in_ch.first_of_run, in_ch.virt_reg,
                                                          in_ch.start_pos, in_ch.end_pos,
                                                          in_ch.is_float, in_ch.crosses_call));
        end
        o_outstanding = expected_allocs.size();
    end

endmodule

### tb/sv/tb_linear_scan_register_allocator_core.sv
// Testbench top: clock, reset, interval and configuration stimulus, and the final verdict
module tb_linear_scan_register_allocator_core import lsra_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;
    int   failures;
    int   outstanding;
    bit   idle_on;
    bit   hold_req;
    int   hold_left;

    lsra_in_if  in_ch ();
    lsra_out_if out_ch ();
    lsra_cfg_if cfg_ch ();

    linear_scan_register_allocator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    lsra_allocation_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .cfg_ch        (cfg_ch),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("[linear_scan_register_allocator_core] ERROR");
        $finish;
    end

    // result receiver: random back-pressure, plus one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        hold_left    = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 400;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !(idle_on && $urandom_range(99) < 18);
            end
        end
    end

    task automatic send_interval(input logic first, input logic [VREG_BITS-1:0] vr,
                                 input logic [POS_BITS-1:0] st, input logic [END_BITS-1:0] en,
                                 input logic fl, input logic call);
        if (idle_on) begin
            while ($urandom_range(99) < 18) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid        <= 1'b1;
        in_ch.first_of_run <= first;
        in_ch.virt_reg     <= vr;
        in_ch.start_pos    <= st;
        in_ch.end_pos      <= en;
        in_ch.is_float     <= fl;
        in_ch.crosses_call <= call;
        do @(negedge i_clk); while (!in_ch.ready);
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_BITS-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(negedge i_clk); while (!cfg_ch.ready);
        @(posedge i_clk);
    endtask

    task automatic set_registers(input logic [CFG_BITS-1:0] gen, input logic [CFG_BITS-1:0] flt,
                                 input logic [CFG_BITS-1:0] base);
        drain_results();
        write_reg(CFG_GENERAL_REG_COUNT, gen);
        write_reg(CFG_FLOAT_REG_COUNT, flt);
        write_reg(CFG_CALLEE_SAVED_BASE, base);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        int          run_left;
        int          pos;
        int          span;
        int          fin;
        int          prev_fin;
        int          r;
        logic [4:0]  gen;
        logic [4:0]  flt;
        logic [4:0]  base;
        in_ch.valid        = 1'b0;
        in_ch.first_of_run = 1'b0;
        in_ch.virt_reg     = '0;
        in_ch.start_pos    = '0;
        in_ch.end_pos      = '0;
        in_ch.is_float     = 1'b0;
        in_ch.crosses_call = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_GENERAL_REG_COUNT;
        cfg_ch.data        = '0;
        idle_on            = 1'b1;
        hold_req           = 1'b0;
        i_rst_n            = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default registers: callee-saved fill, eviction ties, self spill, expiry, odd ends
        send_interval(1'b1, 16'h0000, 20'd0, 21'd1, 1'b0, 1'b0);
        send_interval(1'b0, 16'hFFFF, 20'd0, 21'h100000, 1'b1, 1'b1);
        send_interval(1'b0, 16'h1234, 20'd0, 21'h100000, 1'b0, 1'b1);
        send_interval(1'b0, 16'h2345, 20'd0, 21'h100000, 1'b1, 1'b1);
        send_interval(1'b0, 16'h3456, 20'd0, 21'h0FFFFF, 1'b0, 1'b1);
        send_interval(1'b0, 16'h4567, 20'd0, 21'h0FFFFF, 1'b1, 1'b1);
        send_interval(1'b0, 16'h5678, 20'd0, 21'd16, 1'b0, 1'b1);
        send_interval(1'b0, 16'h6789, 20'd0, 21'h100000, 1'b1, 1'b1);
        send_interval(1'b0, 16'hAAAA, 20'd5, 21'd3, 1'b0, 1'b0);
        send_interval(1'b0, 16'h5555, 20'd6, 21'd0, 1'b0, 1'b0);
        send_interval(1'b0, 16'h0F0F, 20'hFFFFF, 21'h100000, 1'b1, 1'b0);

        // counts above depth, floor above limit, empty float class
        set_registers(5'd31, 5'd0, 5'd20);
        send_interval(1'b1, 16'h0001, 20'd100, 21'd200, 1'b0, 1'b1);
        send_interval(1'b0, 16'h0002, 20'd100, 21'd300, 1'b0, 1'b0);
        send_interval(1'b0, 16'h0003, 20'd101, 21'd150, 1'b1, 1'b0);
        send_interval(1'b0, 16'h0004, 20'd102, 21'd400, 1'b0, 1'b0);
        send_interval(1'b0, 16'h0005, 20'd103, 21'd120, 1'b0, 1'b1);

        set_registers(5'd2, 5'd17, 5'd1);
        send_interval(1'b1, 16'h0010, 20'd0, 21'd50, 1'b0, 1'b0);
        send_interval(1'b0, 16'h0011, 20'd1, 21'd60, 1'b0, 1'b0);
        send_interval(1'b0, 16'h0012, 20'd2, 21'd70, 1'b0, 1'b0);
        send_interval(1'b0, 16'h0013, 20'd3, 21'd40, 1'b1, 1'b0);
        send_interval(1'b0, 16'h0014, 20'd4, 21'd55, 1'b0, 1'b1);

        run_left = 0;
        pos      = 0;
        prev_fin = 0;
        for (int ph = 0; ph < 13; ph++) begin
            case (ph)
                0: set_registers(5'd16, 5'd16, 5'd16);
                1: set_registers(5'd1, 5'd31, 5'd0);
                default: begin
                    r    = $urandom_range(9);
                    gen  = (r == 0) ? 5'($urandom_range(17, 31)) :
                           (r == 1) ? 5'd0 : 5'($urandom_range(1, 16));
                    r    = $urandom_range(9);
                    flt  = (r == 0) ? 5'($urandom_range(17, 31)) :
                           (r == 1) ? 5'd0 : 5'($urandom_range(1, 16));
                    base = ($urandom_range(9) == 0) ? 5'($urandom_range(17, 31)) :
                           5'($urandom_range(0, 16));
                    set_registers(gen, flt, base);
                end
            endcase
            idle_on  = !(ph == 4 || ph == 5);
            run_left = 0;
            if (ph == 3) hold_req = 1'b1;
            for (int n = 0; n < 150; n++) begin
                if (n == 75) drain_results();
                if ($urandom_range(99) < 10) begin
                    send_interval($urandom_range(15) == 0, 16'($urandom), 20'($urandom),
                                  21'($urandom), 1'($urandom_range(1)),
                                  1'($urandom_range(1)));
                end else begin
                    if (run_left == 0) begin
                        run_left = $urandom_range(5, 60);
                        pos      = $urandom_range(0, 20'hFFFFF);
                        prev_fin = 0;
                    end
                    pos = pos + $urandom_range(0, 3);
                    if (pos > 20'hFFFFF) pos = 20'hFFFFF;
                    r = $urandom_range(99);
                    span = (r < 70) ? $urandom_range(1, 40) :
                           (r < 90) ? $urandom_range(1, 400) : $urandom_range(1, 21'h100000);
                    fin = pos + span;
                    if (fin > 21'h100000) fin = 21'h100000;
                    if ($urandom_range(7) == 0 && prev_fin > pos) fin = prev_fin;
                    prev_fin = fin;
                    send_interval(run_left == 60 || prev_fin == 0 ? 1'b0 : 1'b0, 16'($urandom),
                                  20'(pos), 21'(fin), 1'($urandom_range(1)),
                                  $urandom_range(3) == 0);
                    run_left--;
                end
            end
        end

        drain_results();
        if (failures == 0 && outstanding == 0) begin
            $display("[linear_scan_register_allocator_core] OK");
        end else begin
            $display("[linear_scan_register_allocator_core] ERROR");
        end
        $finish;
    end

endmodule
